FILE: design/bcvm_pkg.sv
// ----------------------------------------------------------------------------
// bcvm_pkg
// Shared types and constants for the battery cell voltage monitor.
// ----------------------------------------------------------------------------
package bcvm_pkg;

    // Fixed field widths.
    localparam int NUM_CELLS  = 4;
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 16;
    localparam int ACC_W      = 32;
    localparam int VOLT_W     = 16;
    localparam int CNT_W      = 4;
    localparam int CNT5_W     = 5;
    localparam int CH_W       = 2;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    // Shared divider geometry: 32-bit dividend, 12-bit divisor.
    localparam int QUO_W      = 32;
    localparam int DVS_W      = 12;
    localparam int DIV_CNT_W  = 6;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPW   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WPR   = 2'd2;

    // Reset values and legal ranges of the configuration registers.
    localparam logic [CFG_W-1:0]  SCALE_RST = 16'd6250;
    localparam logic [CNT5_W-1:0] SPW_RST   = 5'd10;
    localparam logic [CNT5_W-1:0] WPR_RST   = 5'd10;
    localparam logic [CNT5_W-1:0] SPW_MIN   = 5'd3;
    localparam logic [CNT5_W-1:0] SPW_MAX   = 5'd16;
    localparam logic [CNT5_W-1:0] WPR_MIN   = 5'd1;
    localparam logic [CNT5_W-1:0] WPR_MAX   = 5'd16;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_ACC,
        ST_AVG_LOAD,
        ST_AVG_DIV,
        ST_OUT
    } t_state;

endpackage

FILE: design/battery_cell_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery_cell_voltage_monitor
// Trimmed-mean cell voltage monitor with one shared serial divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                    Contents
//  s_axis    in         tvalid/tready/tdata[63:0]  one ADC scan of taps and vref
//  m_axis    out        tvalid/tready/tdata[63:0]  four cell averages, tuser=fault
//  cfg       in         we/addr[1:0]/wdata[15:0]   scale, scans/window, windows/report
//
//  A scan that does not close a window is taken without holding the input. A
//  closing scan holds the input off: for each tap channel a multiply, a divider
//  load and a division, then the accumulate step, or only the accumulate step
//  with a zero reference. A report adds a divider load and a division per cell,
//  then the output step, which waits for the output register to free.
//  A held result does not stop scans; only the next report waits for the
//  output register to free. Reset is synchronous, active low, and restores
//  the register defaults.
// ----------------------------------------------------------------------------
module battery_cell_voltage_monitor #(
    parameter int TAP_CHANNELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Scan stream. tdata: tap0, tap1, tap2, tap3, reference (12 bits each).
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bcvm_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // Result stream. tdata: cell0..cell3 voltage (16 bits each).
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [bcvm_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tuser: reference_fault.
    output logic                                o_m_axis_tuser,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [bcvm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [bcvm_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import bcvm_pkg::*;

    localparam int SEL_W = (TAP_CHANNELS > 1) ? $clog2(TAP_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_TAP  = CH_W'(TAP_CHANNELS - 1);
    localparam logic [CH_W-1:0] LAST_CELL = CH_W'(NUM_CELLS - 1);

    // Configuration registers.
    logic [CFG_W-1:0]  r_scale;
    logic [CNT5_W-1:0] r_spw;
    logic [CNT5_W-1:0] r_wpr;

    // Sequencer and counters.
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_scan_cnt;
    logic [CNT_W-1:0]  r_win_cnt;
    logic [CH_W-1:0]   r_ch;
    logic              r_fault;
    logic              r_neg;
    logic [DVS_W-1:0]  r_vref;
    logic [QUO_W-1:0]  r_prod;
    logic [QUO_W-1:0]  r_val [TAP_CHANNELS];
    logic [ACC_W-1:0]  r_acc [NUM_CELLS];
    logic [VOLT_W-1:0] r_avg [NUM_CELLS];

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_fault;

    // Combinational signals.
    t_sample [NUM_CELLS-1:0] w_taps;
    t_sample                 w_vref;
    logic                    w_accept;
    logic [CNT5_W-1:0]       w_spw_eff;
    logic [CNT5_W-1:0]       w_wpr_eff;
    logic                    w_win_close;
    logic                    w_rep_end;
    logic [SUM_W-1:0]        w_trimmed;
    logic [ACC_W-1:0]        w_acc_sel;
    logic [ACC_W-1:0]        w_acc_mag;
    logic                    w_out_free;
    logic                    w_ready;
    logic                    w_div_start;
    logic [QUO_W-1:0]        w_div_dvd;
    logic [DVS_W-1:0]        w_div_dvs;
    logic                    w_div_done;
    logic [QUO_W-1:0]        w_div_quo;
    logic [VOLT_W-1:0]       w_quo16;

    // Unpack the scan.
    always_comb begin
        for (int ch = 0; ch < NUM_CELLS; ch++) begin
            w_taps[ch] = i_s_axis_tdata[ch*SAMPLE_W +: SAMPLE_W];
        end
        w_vref = i_s_axis_tdata[NUM_CELLS*SAMPLE_W +: SAMPLE_W];
    end

    // Effective counts, saturated to their legal ranges.
    always_comb begin
        if (r_spw < SPW_MIN) begin
            w_spw_eff = SPW_MIN;
        end else if (r_spw > SPW_MAX) begin
            w_spw_eff = SPW_MAX;
        end else begin
            w_spw_eff = r_spw;
        end
        if (r_wpr < WPR_MIN) begin
            w_wpr_eff = WPR_MIN;
        end else if (r_wpr > WPR_MAX) begin
            w_wpr_eff = WPR_MAX;
        end else begin
            w_wpr_eff = r_wpr;
        end
        w_win_close = (({1'b0, r_scan_cnt} + 1'b1) >= w_spw_eff);
        w_rep_end   = (({1'b0, r_win_cnt} + 1'b1) >= w_wpr_eff);
    end

    assign w_accept   = i_s_axis_tvalid && w_ready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Accumulator magnitude for the averaging divisions.
    always_comb begin
        w_acc_sel = r_acc[r_ch];
        w_acc_mag = w_acc_sel[ACC_W-1] ? (ACC_W'(0) - w_acc_sel) : w_acc_sel;
        w_quo16   = w_div_quo[VOLT_W-1:0];
    end

    // Window statistics.
    bcvm_scan #(
        .TAP_CHANNELS (TAP_CHANNELS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_load    (w_accept),
        .i_first   (r_scan_cnt == '0),
        .i_taps    (w_taps),
        .i_sel     (r_ch),
        .o_trimmed (w_trimmed)
    );

    // Shared divider.
    bcvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_win_close) begin
                    n_state = (w_vref == '0) ? ST_ACC : ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = (r_ch == LAST_TAP) ? ST_ACC : ST_MUL;
                end
            end
            ST_ACC: begin
                n_state = w_rep_end ? ST_AVG_LOAD : ST_IDLE;
            end
            ST_AVG_LOAD: begin
                n_state = ST_AVG_DIV;
            end
            ST_AVG_DIV: begin
                if (w_div_done) begin
                    n_state = (r_ch == LAST_CELL) ? ST_OUT : ST_AVG_LOAD;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State-decoded outputs: ready and divider operand selection.
    always_comb begin
        w_ready     = 1'b0;
        w_div_start = 1'b0;
        w_div_dvd   = r_prod;
        w_div_dvs   = r_vref;
        unique case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
            end
            ST_LOAD: begin
                w_div_start = 1'b1;
            end
            ST_AVG_LOAD: begin
                w_div_start = 1'b1;
                w_div_dvd   = w_acc_mag;
                w_div_dvs   = DVS_W'(w_wpr_eff);
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_spw   <= SPW_RST;
            r_wpr   <= WPR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SCALE: r_scale <= i_cfg_wdata;
                REG_SPW:   r_spw   <= i_cfg_wdata[CNT5_W-1:0];
                REG_WPR:   r_wpr   <= i_cfg_wdata[CNT5_W-1:0];
                default: begin
                    r_scale <= r_scale;
                end
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan_cnt <= '0;
            r_win_cnt  <= '0;
            r_ch       <= '0;
            r_fault    <= 1'b0;
            for (int k = 0; k < NUM_CELLS; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_ch <= '0;
                    if (w_accept) begin
                        if (w_win_close) begin
                            r_scan_cnt <= '0;
                            if (w_vref == '0) begin
                                r_fault <= 1'b1;
                            end
                        end else begin
                            r_scan_cnt <= r_scan_cnt + 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done && r_ch != LAST_TAP) begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                ST_ACC: begin
                    // Cell k is tap (TAP_CHANNELS-1-k) minus the tap above it.
                    for (int k = 0; k < TAP_CHANNELS; k++) begin
                        if (k == 0) begin
                            r_acc[k] <= r_acc[k] + r_val[TAP_CHANNELS-1];
                        end else begin
                            r_acc[k] <= r_acc[k] + r_val[TAP_CHANNELS-1-k]
                                      - r_val[TAP_CHANNELS-k];
                        end
                    end
                    r_ch <= '0;
                    if (w_rep_end) begin
                        r_win_cnt <= '0;
                    end else begin
                        r_win_cnt <= r_win_cnt + 1'b1;
                    end
                end
                ST_AVG_DIV: begin
                    if (w_div_done) begin
                        r_acc[r_ch] <= '0;
                        if (r_ch != LAST_CELL) begin
                            r_ch <= r_ch + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_fault <= 1'b0;
                    end
                end
                default: begin
                    r_ch <= r_ch;
                end
            endcase
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_win_close) begin
                    r_vref <= w_vref;
                    // A zero reference makes the window contribute nothing.
                    if (w_vref == '0) begin
                        for (int ch = 0; ch < TAP_CHANNELS; ch++) begin
                            r_val[ch] <= '0;
                        end
                    end
                end
            end
            ST_MUL: begin
                r_prod <= QUO_W'(w_trimmed) * QUO_W'(r_scale);
            end
            ST_DIV: begin
                if (w_div_done) begin
                    r_val[r_ch[SEL_W-1:0]] <= w_div_quo;
                end
            end
            ST_AVG_LOAD: begin
                r_neg <= w_acc_sel[ACC_W-1];
            end
            ST_AVG_DIV: begin
                if (w_div_done) begin
                    r_avg[r_ch] <= r_neg ? (VOLT_W'(0) - w_quo16) : w_quo16;
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    // Output register: loaded once the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_out_data  <= {r_avg[3], r_avg[2], r_avg[1], r_avg[0]};
            r_out_fault <= r_fault;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_fault;

endmodule

FILE: design/bcvm_div.sv
// ----------------------------------------------------------------------------
// bcvm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcvm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bcvm_pkg::QUO_W-1:0] i_dividend,
    input  logic [bcvm_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [bcvm_pkg::QUO_W-1:0] o_quotient
);
    import bcvm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [QUO_W-1:0]     r_quo;

    logic [DVS_W:0]       w_shift;
    logic [DVS_W:0]       w_diff;
    logic                 w_ge;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        w_shift = {r_rem, r_quo[QUO_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
    end

    // Control: a start loads the operands and runs one step per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out on top, quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/bcvm_scan.sv
// ----------------------------------------------------------------------------
// bcvm_scan
// Per-channel window statistics: running sum, maximum and minimum.
// ----------------------------------------------------------------------------
module bcvm_scan #(
    parameter int TAP_CHANNELS = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_load,
    input  logic                                          i_first,
    input  bcvm_pkg::t_sample [bcvm_pkg::NUM_CELLS-1:0]  i_taps,
    input  logic [bcvm_pkg::CH_W-1:0]                     i_sel,
    output logic [bcvm_pkg::SUM_W-1:0]                    o_trimmed
);
    import bcvm_pkg::*;

    localparam int SEL_W = (TAP_CHANNELS > 1) ? $clog2(TAP_CHANNELS) : 1;

    logic [SUM_W-1:0] r_sum [TAP_CHANNELS];
    t_sample          r_max [TAP_CHANNELS];
    t_sample          r_min [TAP_CHANNELS];

    // The first scan of a window seeds all three; later scans fold in.
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < TAP_CHANNELS; ch++) begin
            if (i_load) begin
                if (i_first) begin
                    r_sum[ch] <= SUM_W'(i_taps[ch]);
                    r_max[ch] <= i_taps[ch];
                    r_min[ch] <= i_taps[ch];
                end else begin
                    r_sum[ch] <= r_sum[ch] + SUM_W'(i_taps[ch]);
                    if (i_taps[ch] > r_max[ch]) begin
                        r_max[ch] <= i_taps[ch];
                    end
                    if (i_taps[ch] < r_min[ch]) begin
                        r_min[ch] <= i_taps[ch];
                    end
                end
            end
        end
    end

    // Trimmed sum of the selected channel; a window holds at least three
    // scans, so it never goes negative.
    always_comb begin
        o_trimmed = r_sum[i_sel[SEL_W-1:0]]
                  - SUM_W'(r_max[i_sel[SEL_W-1:0]])
                  - SUM_W'(r_min[i_sel[SEL_W-1:0]]);
    end

endmodule

FILE: design/bcvm_checker.sv
// ----------------------------------------------------------------------------
// bcvm_port_checks
// Port-level checks of the battery cell voltage monitor, bound to the top.
// ----------------------------------------------------------------------------
module bcvm_port_checks (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            o_s_axis_tready,
    input  logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [bcvm_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                            o_m_axis_tuser
);
    import bcvm_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // After reset the block is ready and shows no result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("bad state after reset");

    // A new result only appears after the sequencer has been busy.
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared while idle");

    // An accepted scan never produces a result in the very next cycle.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result too soon after a scan");

endmodule

bind battery_cell_voltage_monitor bcvm_port_checks u_bcvm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: tb/bcvm_checker.sv
// ----------------------------------------------------------------------------
// bcvm_checker
// Watches the scan, report and register channels of the cell voltage
// monitor. It keeps its own copy of the window and report state, predicts
// every cell report from the accepted scans and compares each accepted
// report against the oldest prediction.
// ----------------------------------------------------------------------------
module bcvm_checker #(
    parameter int TAP_CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Scan channel. tdata: tap0, tap1, tap2, tap3, reference (12 bits each).
    input  logic                            i_s_valid,
    input  logic                            i_s_ready,
    input  logic [bcvm_pkg::IN_DATA_W-1:0]  i_s_data,
    // Report channel. tdata: cell0..cell3 voltage (16 bits each).
    input  logic                            i_m_valid,
    input  logic                            i_m_ready,
    input  logic [bcvm_pkg::OUT_DATA_W-1:0] i_m_data,
    // tuser: reference_fault.
    input  logic                            i_m_user,
    // Register writes.
    input  logic                            i_cfg_we,
    input  logic [bcvm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bcvm_pkg::CFG_W-1:0]      i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_reports_seen
);
    import bcvm_pkg::*;

    // One cell report: cell_mv[0] sits in the low 16 bits of tdata.
    typedef struct packed {
        logic [NUM_CELLS-1:0][VOLT_W-1:0] cell_mv;
        logic                             fault;
    } t_cell_report;

    localparam int PRINT_LIMIT = 40;

    // Register copies, raw as written.
    logic [CFG_W-1:0]    scale_mv;
    logic [CNT5_W-1:0]   spw_raw;
    logic [CNT5_W-1:0]   wpr_raw;

    // Window and report state.
    logic [SUM_W-1:0]    win_sum [NUM_CELLS];
    logic [SAMPLE_W-1:0] win_max [NUM_CELLS];
    logic [SAMPLE_W-1:0] win_min [NUM_CELLS];
    logic [CNT_W-1:0]    scans_taken;
    logic [CNT_W-1:0]    windows_taken;
    logic [ACC_W-1:0]    cell_acc [NUM_CELLS];
    logic                fault_latched;

    t_cell_report        expected_reports [$];

    function automatic int clamp_count(input int v, input int lo, input int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Fold one scan into the window; close the window and the report when
    // their counts are reached.
    task automatic absorb_scan(input logic [IN_DATA_W-1:0] scan, output bit due,
                               output t_cell_report rpt);
        int                  spw;
        int                  wpr;
        int                  ch;
        int                  tap;
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0] vref;
        logic [63:0]         trimmed;
        logic [63:0]         quot;
        logic [ACC_W-1:0]    win_val [NUM_CELLS];
        logic [ACC_W-1:0]    below;
        logic signed [31:0]  acc_s;
        logic signed [31:0]  avg;
        due  = 1'b0;
        rpt  = '0;
        spw  = clamp_count(int'(spw_raw), int'(SPW_MIN), int'(SPW_MAX));
        wpr  = clamp_count(int'(wpr_raw), int'(WPR_MIN), int'(WPR_MAX));
        vref = scan[NUM_CELLS*SAMPLE_W +: SAMPLE_W];

        // The first scan of a window loads sum, max and min.
        for (ch = 0; ch < TAP_CHANNELS; ch++) begin
            smp = scan[SAMPLE_W*ch +: SAMPLE_W];
            if (scans_taken == 0) begin
                win_sum[ch] = {4'd0, smp};
                win_max[ch] = smp;
                win_min[ch] = smp;
            end else begin
                win_sum[ch] = win_sum[ch] + {4'd0, smp};
                if (smp > win_max[ch]) begin
                    win_max[ch] = smp;
                end
                if (smp < win_min[ch]) begin
                    win_min[ch] = smp;
                end
            end
        end
        if (int'(scans_taken) + 1 < spw) begin
            scans_taken = scans_taken + 1'b1;
            return;
        end
        scans_taken = '0;

        // Trimmed sum scaled against the last reference; zero reference
        // contributes nothing and flags a fault.
        for (ch = 0; ch < NUM_CELLS; ch++) begin
            win_val[ch] = '0;
            if (ch < TAP_CHANNELS && vref != 0) begin
                trimmed = {48'd0, win_sum[ch]} - {52'd0, win_max[ch]}
                          - {52'd0, win_min[ch]};
                quot    = (trimmed * {48'd0, scale_mv}) / {52'd0, vref};
                win_val[ch] = quot[31:0];
            end
        end
        if (vref == 0) begin
            fault_latched = 1'b1;
        end

        // Cell k is the difference of adjacent taps, counted from the top.
        below = '0;
        for (ch = 0; ch < TAP_CHANNELS; ch++) begin
            tap          = TAP_CHANNELS - 1 - ch;
            cell_acc[ch] = cell_acc[ch] + (win_val[tap] - below);
            below        = win_val[tap];
        end
        if (int'(windows_taken) + 1 < wpr) begin
            windows_taken = windows_taken + 1'b1;
            return;
        end
        windows_taken = '0;

        // Signed average, truncated toward zero, low 16 bits kept.
        for (ch = 0; ch < NUM_CELLS; ch++) begin
            acc_s             = cell_acc[ch];
            avg               = acc_s / wpr;
            rpt.cell_mv[ch]   = avg[VOLT_W-1:0];
            cell_acc[ch]      = '0;
        end
        rpt.fault     = fault_latched;
        fault_latched = 1'b0;
        due           = 1'b1;
    endtask

    // Track all three channels at each rising edge.
    always @(posedge i_clk) begin : track
        t_cell_report rpt;
        t_cell_report want;
        bit           due;
        int           ch;
        if (!i_rst_n) begin
            scale_mv      = SCALE_RST;
            spw_raw       = SPW_RST;
            wpr_raw       = WPR_RST;
            scans_taken   = '0;
            windows_taken = '0;
            fault_latched = 1'b0;
            for (ch = 0; ch < NUM_CELLS; ch++) begin
                win_sum[ch]  = '0;
                win_max[ch]  = '0;
                win_min[ch]  = '0;
                cell_acc[ch] = '0;
            end
            expected_reports.delete();
        end else begin
            // Check each accepted report request against the oldest prediction.
            if (i_m_valid && i_m_ready) begin
                o_reports_seen++;
                if (expected_reports.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= PRINT_LIMIT) begin
                        $display("%0t: unexpected report, expected none, actual %h fault %b",
                                 $time, i_m_data, i_m_user);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    for (ch = 0; ch < NUM_CELLS; ch++) begin
                        if (i_m_data[VOLT_W*ch +: VOLT_W] !== want.cell_mv[ch]) begin
                            o_fail_count++;
                            if (o_fail_count <= PRINT_LIMIT) begin
                                $display("%0t: cell%0d voltage expected %0d, actual %0d",
                                         $time, ch, $signed(want.cell_mv[ch]),
                                         $signed(i_m_data[VOLT_W*ch +: VOLT_W]));
                            end
                        end
                    end
                    if (i_m_user !== want.fault) begin
                        o_fail_count++;
                        if (o_fail_count <= PRINT_LIMIT) begin
                            $display("%0t: reference fault expected %b, actual %b",
                                     $time, want.fault, i_m_user);
                        end
                    end
                end
            end

            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SCALE: begin
                        scale_mv = i_cfg_wdata;
                    end
                    REG_SPW: begin
                        spw_raw = i_cfg_wdata[CNT5_W-1:0];
                    end
                    REG_WPR: begin
                        wpr_raw = i_cfg_wdata[CNT5_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Predict from each accepted scan request.
            if (i_s_valid && i_s_ready) begin
                absorb_scan(i_s_data, due, rpt);
                if (due) begin
                    expected_reports.push_back(rpt);
                end
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the battery cell voltage monitor. A short directed
// set of scans covers the sample extremes, a zero and a tiny reference and
// max/min order within a window; then random scans run through a series of
// register settings, including out-of-range counts and zero scaling, under
// changing stall patterns and one long hold-off on the report side. The
// checker predicts and compares; this module only drives and decides.
// ----------------------------------------------------------------------------
module testbench;
    import bcvm_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 3000;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 150;
    localparam int EXTRA_ITEMS   = 60;
    localparam int MIN_REPORTS   = 48;
    localparam logic [SAMPLE_W-1:0] FULL = 12'hFFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic [IN_DATA_W-1:0]  s_data;
    logic                  m_ready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;

    int fail_count;
    int pending;
    int reports_seen;
    int src_idle_pct;
    int dst_idle_pct;
    int hold_requests;

    battery_cell_voltage_monitor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    bcvm_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (s_valid),
        .i_s_ready      (o_s_axis_tready),
        .i_s_data       (s_data),
        .i_m_valid      (o_m_axis_tvalid),
        .i_m_ready      (m_ready),
        .i_m_data       (o_m_axis_tdata),
        .i_m_user       (o_m_axis_tuser),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_reports_seen (reports_seen)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [IN_DATA_W-1:0] pack_scan(
        input logic [SAMPLE_W-1:0] t0, input logic [SAMPLE_W-1:0] t1,
        input logic [SAMPLE_W-1:0] t2, input logic [SAMPLE_W-1:0] t3,
        input logic [SAMPLE_W-1:0] vref);
        return {4'd0, vref, t3, t2, t1, t0};
    endfunction

    // Taps lean toward the rails; the reference is sometimes zero and often tiny.
    function automatic logic [SAMPLE_W-1:0] pick_tap();
        int r;
        r = $urandom_range(7);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return FULL;
        end
        return SAMPLE_W'($urandom_range(4095));
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_scan();
        int                  r;
        logic [SAMPLE_W-1:0] vref;
        r = $urandom_range(15);
        if (r == 0) begin
            vref = '0;
        end else if (r <= 4) begin
            vref = SAMPLE_W'($urandom_range(8, 1));
        end else begin
            vref = SAMPLE_W'($urandom_range(4095));
        end
        return pack_scan(pick_tap(), pick_tap(), pick_tap(), pick_tap(), vref);
    endfunction

    // Offer one scan request, idling at random first; returns at a falling edge.
    task automatic send_scan(input logic [IN_DATA_W-1:0] scan);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= random_scan();
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= scan;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Write all three registers on consecutive cycles; upper bits of the
    // count registers are random since only five bits are kept.
    task automatic program_regs(input int scale, input int spw, input int wpr);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SCALE;
        cfg_wdata <= CFG_W'(scale);
        @(negedge i_clk);
        cfg_addr  <= REG_SPW;
        cfg_wdata <= {11'($urandom), 5'(spw)};
        @(negedge i_clk);
        cfg_addr  <= REG_WPR;
        cfg_wdata <= {11'($urandom), 5'(wpr)};
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every report has arrived, then let a window close finish.
    task automatic settle();
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Report side: random stalls, plus long hold-offs on request.
    initial begin : report_sink
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        m_ready      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no request accepted.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || cfg_we) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("battery_cell_voltage_monitor test failed");
        $finish;
    end

    // Main stimulus.
    initial begin : stimulus
        int ph;
        i_rst_n       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_SCALE;
        cfg_wdata     = '0;
        src_idle_pct  = 15;
        dst_idle_pct  = 66;
        hold_requests = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Directed windows of three scans, one report each.
        program_regs(65535, 3, 1);
        // Full-scale taps.
        repeat (3) send_scan(pack_scan(FULL, FULL, FULL, FULL, FULL));
        // All taps at zero.
        repeat (3) send_scan(pack_scan('0, '0, '0, '0, FULL));
        // Zero reference on the closing scan.
        repeat (3) send_scan(pack_scan(FULL, 12'd3000, 12'd2000, 12'd1000, '0));
        // Max and min arrive in different orders per channel; tiny reference.
        send_scan(pack_scan(12'd2000, '0, FULL, 12'd100, 12'd77));
        send_scan(pack_scan(FULL, 12'd2000, '0, 12'd100, 12'd900));
        send_scan(pack_scan('0, FULL, 12'd2000, FULL, 12'd1));
        // Alternating bit patterns.
        send_scan(pack_scan(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h555));
        send_scan(pack_scan(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'hAAA));
        send_scan(pack_scan(12'hAAA, 12'hAAA, 12'h555, 12'h555, 12'hAAA));
        // Rising taps give negative cells.
        repeat (3) send_scan(pack_scan('0, 12'd1000, 12'd2000, FULL, 12'd1));
        s_valid <= 1'b0;

        // Random phases, each under its own register setting.
        for (ph = 1; ph <= 9; ph++) begin
            settle();
            case (ph)
                1: program_regs(65535, 16, 1);
                2: program_regs(0, 2, 0);
                3: program_regs(1, 31, 2);
                4: program_regs(6250, 3, 16);
                5: program_regs($urandom_range(65535, 1), 0, 31);
                6: program_regs($urandom_range(65535, 1), $urandom_range(6, 3),
                                $urandom_range(4, 1));
                7: program_regs($urandom_range(65535, 1), 3, 1);
                8: program_regs(65535, $urandom_range(31), $urandom_range(31));
                default: program_regs($urandom_range(65535), 4, 3);
            endcase
            if (ph <= 3) begin
                src_idle_pct = 15;
                dst_idle_pct = 66;
            end else if (ph <= 6) begin
                src_idle_pct = 66;
                dst_idle_pct = 15;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            // Hold the report side off so the block fills up and stalls scans.
            if (ph == 7) begin
                hold_requests++;
            end
            repeat (PHASE_ITEMS) send_scan(random_scan());
            s_valid <= 1'b0;
        end

        // Keep going with short windows if reports were scarce.
        while (reports_seen + pending < MIN_REPORTS) begin
            settle();
            program_regs($urandom_range(65535, 1), 3, 1);
            repeat (EXTRA_ITEMS) send_scan(random_scan());
            s_valid <= 1'b0;
        end

        settle();
        if (fail_count == 0) begin
            $display("battery_cell_voltage_monitor test passed");
        end else begin
            $display("battery_cell_voltage_monitor test failed");
        end
        $finish;
    end

endmodule
